@@ sv/rtq_pkg.sv @@
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared types and constants for the reset trigger qualifier.
// ----------------------------------------------------------------------------
package rtq_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam int SAMPLE_W    = 16;
    localparam int CHANNEL_W   = 2;
    localparam int PERIOD_W    = 24;
    localparam int FRACTION_W  = 6;
    localparam int FILTER_SHIFT = 6;
    // Quotient bits of the crossing divide; the quotient stays below 32.
    localparam int QUOT_BITS   = 5;
    localparam int STEP_CNT_W  = 3;

    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_LOW_RST  = 16'sd10000;
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_HIGH_RST = 16'sd20000;

    // Configuration register indexes
    localparam logic REG_THRESHOLD_LOW  = 1'b0;
    localparam logic REG_THRESHOLD_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

endpackage

@@ sv/reset_trigger_qualifier_top.sv @@
// ----------------------------------------------------------------------------
// reset_trigger_qualifier_top
// Per-channel CV smoothing, hysteresis trigger, crossing estimate and period.
// ----------------------------------------------------------------------------
// One request in, one result out. Each request carries a channel number, a
// control-voltage sample and a reset-input sample. The CV passes through a
// one-pole low-pass (step of 1/64 toward the new sample). The reset sample
// goes through a Schmitt trigger: below threshold_low arms the channel,
// above threshold_high while armed fires and disarms it. On a fire the block
// estimates where threshold_high was crossed between the previous and the
// current reset sample, in 32nds, with a restoring divider that produces one
// quotient bit per cycle. Each channel counts its requests since its last
// fire; the result reports the count before the update, then a fire clears
// it and any other request increments it, saturating. A channel number at or
// above CHANNELS changes no state and returns a result with all fields but
// channel_out at zero. Timing: one request is in work at a time. A request
// without a crossing divide goes from accept through ST_OUTPUT to ST_IDLE;
// a fire whose previous sample sat at or below threshold_high also passes
// through ST_DIVIDE first. The output register lets the next request enter
// while a result still waits for out_ready. Configuration writes are always
// taken (cfg_ready is high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module reset_trigger_qualifier_top
    import rtq_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,

    // Configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [SAMPLE_W-1:0]         cfg_data,

    // Request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CHANNEL_W-1:0]        channel,
    input  logic signed [SAMPLE_W-1:0]  cv_sample,
    input  logic signed [SAMPLE_W-1:0]  reset_sample,

    // Result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CHANNEL_W-1:0]        channel_out,
    output logic signed [SAMPLE_W-1:0]  smoothed_cv,
    output logic                        fired,
    output logic [FRACTION_W-1:0]       crossing_fraction,
    output logic [PERIOD_W-1:0]         period_ticks
);

    // Index width for the per-channel state
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Common width for fitting the count into the period field
    localparam int EXT_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] thr_low_reg;
    logic signed [SAMPLE_W-1:0] thr_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg  <= THRESHOLD_LOW_RST;
            thr_high_reg <= THRESHOLD_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD_LOW:  thr_low_reg  <= cfg_data;
                REG_THRESHOLD_HIGH: thr_high_reg <= cfg_data;
                default:            thr_low_reg  <= thr_low_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-channel state
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] smooth_reg [CHANNELS];
    logic                       armed_reg  [CHANNELS];
    logic signed [SAMPLE_W-1:0] prev_reg   [CHANNELS];
    logic [COUNT_WIDTH-1:0]     tick_reg   [CHANNELS];

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   accept;
    logic   out_load;

    // Work registers for the request in flight
    logic [CHANNEL_W-1:0]        ch_reg;
    logic signed [SAMPLE_W-1:0]  smooth_res_reg;
    logic                        fired_reg;
    logic [PERIOD_W-1:0]         period_reg;
    logic [SAMPLE_W-1:0]         rem_reg;
    logic [SAMPLE_W-1:0]         div_reg;
    logic [QUOT_BITS-1:0]        quo_reg;
    logic [STEP_CNT_W-1:0]       step_cnt_reg;

    // Output register
    logic                        out_valid_reg;
    logic [CHANNEL_W-1:0]        channel_out_reg;
    logic signed [SAMPLE_W-1:0]  smoothed_cv_reg;
    logic                        fired_out_reg;
    logic [FRACTION_W-1:0]       fraction_reg;
    logic [PERIOD_W-1:0]         period_out_reg;

    // ------------------------------------------------------------------
    // Request datapath (evaluated in the accept cycle)
    // ------------------------------------------------------------------
    logic                          ch_ok;
    logic [CIW-1:0]                idx;
    logic signed [SAMPLE_W-1:0]    s_cur;
    logic signed [SAMPLE_W:0]      cv_diff;
    logic signed [SAMPLE_W:0]      cv_step;
    logic signed [SAMPLE_W:0]      s_sum;
    logic signed [SAMPLE_W-1:0]    s_new;
    logic                          arm_now;
    logic                          armed_mid;
    logic                          fire;
    logic signed [SAMPLE_W-1:0]    prev_cur;
    logic                          div_start;
    logic signed [SAMPLE_W:0]      to_trig;
    logic signed [SAMPLE_W:0]      to_next;
    logic [COUNT_WIDTH-1:0]        cnt_cur;
    logic [EXT_W-1:0]              cnt_ext;

    assign ch_ok   = 32'(channel) < CHANNELS;
    assign idx     = CIW'(channel);
    assign s_cur   = smooth_reg[idx];
    assign prev_cur = prev_reg[idx];
    assign cnt_cur = tick_reg[idx];
    assign cnt_ext = EXT_W'(cnt_cur);

    // One-pole filter: arithmetic shift gives the floor of diff / 64
    assign cv_diff = {cv_sample[SAMPLE_W-1], cv_sample} - {s_cur[SAMPLE_W-1], s_cur};
    assign cv_step = cv_diff >>> FILTER_SHIFT;
    assign s_sum   = {s_cur[SAMPLE_W-1], s_cur} + cv_step;
    assign s_new   = s_sum[SAMPLE_W-1:0];

    // Arm test first, then fire test
    assign arm_now   = reset_sample < thr_low_reg;
    assign armed_mid = arm_now | armed_reg[idx];
    assign fire      = ch_ok && (reset_sample > thr_high_reg) && armed_mid;

    // Crossing estimate only when the previous sample sat at or below the
    // high threshold; then 0 <= to_trig < to_next and the quotient is < 32.
    assign div_start = fire && (prev_cur <= thr_high_reg);
    assign to_trig   = {thr_high_reg[SAMPLE_W-1], thr_high_reg}
                       - {prev_cur[SAMPLE_W-1], prev_cur};
    assign to_next   = {reset_sample[SAMPLE_W-1], reset_sample}
                       - {prev_cur[SAMPLE_W-1], prev_cur};

    // ------------------------------------------------------------------
    // Restoring divide step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [SAMPLE_W:0] rem_dbl;
    logic [SAMPLE_W:0] rem_sub;
    logic              q_bit;

    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, div_reg};
    assign q_bit   = rem_dbl >= {1'b0, div_reg};

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = div_start ? ST_DIVIDE : ST_OUTPUT;
            end
            ST_DIVIDE:
            begin
                // Last quotient bit lands this cycle
                if (step_cnt_reg == STEP_CNT_W'(QUOT_BITS - 1))
                    state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                // Hand off once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign accept = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Per-channel state update at accept
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                smooth_reg[i] <= '0;
                armed_reg[i]  <= 1'b0;
                prev_reg[i]   <= '0;
                tick_reg[i]   <= '0;
            end
        end
        else if (accept && ch_ok)
        begin
            smooth_reg[idx] <= s_new;
            armed_reg[idx]  <= armed_mid & ~fire;
            prev_reg[idx]   <= reset_sample;
            if (fire)
                tick_reg[idx] <= '0;
            else if (cnt_cur != COUNT_MAX)
                tick_reg[idx] <= cnt_cur + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Work registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg         <= channel;
            smooth_res_reg <= ch_ok ? s_new : '0;
            fired_reg      <= fire;
            period_reg     <= ch_ok ? cnt_ext[PERIOD_W-1:0] : '0;
            rem_reg        <= to_trig[SAMPLE_W-1:0];
            div_reg        <= to_next[SAMPLE_W-1:0];
            quo_reg        <= '0;
            step_cnt_reg   <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            rem_reg      <= q_bit ? rem_sub[SAMPLE_W-1:0] : rem_dbl[SAMPLE_W-1:0];
            quo_reg      <= {quo_reg[QUOT_BITS-2:0], q_bit};
            step_cnt_reg <= step_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            channel_out_reg <= ch_reg;
            smoothed_cv_reg <= smooth_res_reg;
            fired_out_reg   <= fired_reg;
            // Quotient stays zero unless the divide ran
            fraction_reg    <= FRACTION_W'(quo_reg);
            period_out_reg  <= period_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign channel_out       = channel_out_reg;
    assign smoothed_cv       = smoothed_cv_reg;
    assign fired             = fired_out_reg;
    assign crossing_fraction = fraction_reg;
    assign period_ticks      = period_out_reg;

endmodule
